// ----- design/mme_pkg.sv -----
// Shared types, constants and helpers for the matrix multiply engine.
// Used by the engine, cell and checker modules; depends on nothing.
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int SIZE_W      = 4;
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 16;
  localparam int RES_W       = 32;
  localparam int ACC_W       = 36;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FEED,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        k;
    logic signed [VAL_W-1:0] a;
  } link_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] cap);
    eff_size = (r > cap) ? cap : r;
  endfunction

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}});
    lo = $signed({{(ACC_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}});
    if (v > hi) begin
      sat_res = hi[RES_W-1:0];
    end else if (v < lo) begin
      sat_res = lo[RES_W-1:0];
    end else begin
      sat_res = v[RES_W-1:0];
    end
  endfunction

endpackage

// ----- design/matrix_multiply_engine.sv -----
// Matrix multiply engine, C = A x B on Q8.8 elements, Q16.16 saturated results.
// Load requests are taken only while idle; a start runs, per row of C, a clear step,
// a feed over the inner index, a drain through the chain of MAC cells, then output.
// Results leave through a one-deep output register; a row drains before the next.
// Reset (rst, synchronous) sets all sizes to 8 and idles; stores are not cleared.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS     = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int KW        = $clog2(CELLS);
  localparam int AAW       = $clog2(CELLS * CELLS);
  localparam int DRAIN_CYC = CELLS + 3;
  localparam int DW        = $clog2(DRAIN_CYC + 1);
  localparam logic [SIZE_W-1:0] CAP = SIZE_W'(CELLS);

  logic [SIZE_W-1:0] rows_a, inner_size, cols_b;
  logic [SIZE_W-1:0] m_eff, n_eff, p_eff;
  state_t            state, state_next;
  logic [SIZE_W-1:0] i_cnt, j_cnt, k_cnt;
  logic [DW-1:0]     wcnt;
  logic              hd_valid;
  logic [IDX_W-1:0]  hd_k;

  logic                    in_ok, cfg_wr, slot_free;
  action_t                 act;
  logic [IDX_W-1:0]        in_row, in_col;
  logic signed [VAL_W-1:0] in_val;
  logic                    a_we, b_we_any, start_ok;
  logic [AAW-1:0]          a_waddr, a_raddr;
  logic signed [VAL_W-1:0] a_rdata;
  logic                    clr, feed, load_out, row_done, last_k, last_j;

  link_t                   link [CELLS+1];
  logic signed [RES_W-1:0] res  [CELLS];

  logic [IDX_W-1:0]        out_row, out_col;
  logic signed [RES_W-1:0] out_val;
  logic                    out_last;

  assign m_eff = eff_size(rows_a, CAP);
  assign n_eff = eff_size(inner_size, CAP);
  assign p_eff = eff_size(cols_b, CAP);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= SIZE_W'(8);
      inner_size <= SIZE_W'(8);
      cols_b     <= SIZE_W'(8);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ROWS_A: rows_a     <= pwdata[SIZE_W-1:0];
        REG_INNER:  inner_size <= pwdata[SIZE_W-1:0];
        REG_COLS_B: cols_b     <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ROWS_A: prdata = {{(32-SIZE_W){1'b0}}, rows_a};
      REG_INNER:  prdata = {{(32-SIZE_W){1'b0}}, inner_size};
      REG_COLS_B: prdata = {{(32-SIZE_W){1'b0}}, cols_b};
      default:    prdata = '0;
    endcase
  end

  // input decode
  assign in_ok  = s_tvalid & s_tready;
  assign act    = action_t'(s_tuser);
  assign in_row = s_tdata[2:0];
  assign in_col = s_tdata[5:3];
  assign in_val = s_tdata[21:6];

  assign a_we     = in_ok && (act == ACT_LOAD_A) && ({1'b0, in_row} < m_eff)
                    && ({1'b0, in_col} < n_eff);
  assign b_we_any = in_ok && (act == ACT_LOAD_B) && ({1'b0, in_row} < n_eff)
                    && ({1'b0, in_col} < p_eff);
  assign start_ok = in_ok && (act == ACT_START) && (m_eff != '0) && (p_eff != '0);
  assign a_waddr  = AAW'(int'(in_row) * CELLS + int'(in_col));
  assign a_raddr  = AAW'(int'(i_cnt) * CELLS + int'(k_cnt));

  mme_ram #(.WIDTH(VAL_W), .DEPTH(CELLS * CELLS)) u_astore (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_val),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // chain of cells
  assign link[0] = '{valid: hd_valid, k: hd_k, a: a_rdata};

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    mme_cell #(.CELLS(CELLS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .b_we     (b_we_any && (in_col == IDX_W'(g))),
      .b_waddr  (in_row),
      .b_wdata  (in_val),
      .result   (res[g])
    );
  end

  // sequencer
  assign slot_free = !m_tvalid || m_tready;
  assign last_k    = (k_cnt + 1'b1 == n_eff);
  assign last_j    = (j_cnt + 1'b1 == p_eff);
  assign row_done  = (i_cnt + 1'b1 == m_eff);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start_ok) state_next = ST_CLEAR;
      ST_CLEAR: state_next = (n_eff == '0) ? ST_DRAIN : ST_FEED;
      ST_FEED:  if (last_k) state_next = ST_DRAIN;
      ST_DRAIN: if (wcnt == DW'(DRAIN_CYC - 1)) state_next = ST_OUT;
      ST_OUT:   if (load_out && last_j) state_next = row_done ? ST_IDLE : ST_CLEAR;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    clr      = 1'b0;
    feed     = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_CLEAR: clr      = 1'b1;
      ST_FEED:  feed     = 1'b1;
      ST_OUT:   load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      hd_valid <= feed;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    hd_k <= k_cnt[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        i_cnt <= '0;
      end
      ST_CLEAR: begin
        k_cnt <= '0;
        j_cnt <= '0;
        wcnt  <= '0;
      end
      ST_FEED: begin
        k_cnt <= k_cnt + 1'b1;
      end
      ST_DRAIN: begin
        wcnt <= wcnt + 1'b1;
      end
      ST_OUT: begin
        if (load_out) begin
          j_cnt <= j_cnt + 1'b1;
          if (last_j) begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_row  <= i_cnt[IDX_W-1:0];
      out_col  <= j_cnt[IDX_W-1:0];
      out_val  <= res[j_cnt[KW-1:0]];
      out_last <= last_j && row_done;
    end
  end

  assign m_tdata = {2'b00, out_val, out_col, out_row};
  assign m_tlast = out_last;

endmodule

// ----- design/mme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the A store and for each cell's column of B.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mme_cell.sv -----
// One multiply-accumulate cell: holds one column of B and one result sum.
// Depends on mme_pkg and mme_ram; passes the A element on to its neighbor.
module mme_cell import mme_pkg::*; #(
  parameter int CELLS = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  link_t                   link_in,
  output link_t                   link_out,
  input  logic                    b_we,
  input  logic [IDX_W-1:0]        b_waddr,
  input  logic signed [VAL_W-1:0] b_wdata,
  output logic signed [RES_W-1:0] result
);

  localparam int KW = $clog2(CELLS);

  logic signed [VAL_W-1:0] b_rdata;
  link_t                   s1;
  logic                    p_valid;
  logic signed [RES_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  mme_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_bcol (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr[KW-1:0]),
    .wdata (b_wdata),
    .raddr (link_in.k[KW-1:0]),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      p_valid  <= 1'b0;
    end else begin
      s1.valid <= link_in.valid;
      p_valid  <= s1.valid;
    end
    s1.k <= link_in.k;
    s1.a <= link_in.a;
    prod <= s1.a * b_rdata;
    if (clr) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign link_out = s1;
  assign result   = sat_res(acc);

endmodule

// ----- design/mme_checker.sv -----
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg; tracks the row and column size registers from configuration requests.
module mme_checker import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata
);

  localparam logic [SIZE_W-1:0] CAP = SIZE_W'((MAX_DIM < 8) ? MAX_DIM : 8);

  logic [SIZE_W-1:0] rows_sh, cols_sh, rows_eff, cols_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_sh <= SIZE_W'(8);
      cols_sh <= SIZE_W'(8);
    end else if (psel && penable && pwrite) begin
      if (paddr[3:2] == REG_ROWS_A) rows_sh <= pwdata[SIZE_W-1:0];
      if (paddr[3:2] == REG_COLS_B) cols_sh <= pwdata[SIZE_W-1:0];
    end
  end

  assign rows_eff = eff_size(rows_sh, CAP);
  assign cols_eff = eff_size(cols_sh, CAP);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_START) && (rows_eff != '0) && (cols_eff != '0)
    |=> !s_tready)
    else $error("input still ready after start");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
    ({1'b0, m_tdata[2:0]} == rows_eff - 1'b1) && ({1'b0, m_tdata[5:3]} == cols_eff - 1'b1))
    else $error("last flag on wrong element");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_engine mme_checker #(.MAX_DIM(MAX_DIM)) u_mme_checker (.*);
